### hw/rtl/prac_pkg.sv
package prac_pkg;

    // Coordinate word
    typedef logic signed [31:0] coord_t;

    // Offset and center carried through the angle-reduction stages
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        coord_t             cx;
        coord_t             cy;
    } geom_t;

    // Center carried through the rotation and gain stages
    typedef struct packed {
        coord_t cx;
        coord_t cy;
    } center_t;

    // Fraction bits added to the offset inside the rotation datapath
    localparam int GUARD_BITS = 8;

    // Full turn and half turn in degrees
    localparam int DEG_FULL = 360;
    localparam int DEG_HALF = 180;

    // Rounding term of the degree-to-turn conversion, divided by eight
    localparam int ROUND_EIGHTHS = DEG_HALF / 8;

    // Divide by 45 through a reciprocal, exact for inputs below 2^24
    localparam int          DIV45_DIVISOR = 45;
    localparam logic [23:0] DIV45_RECIP   = 24'd11930465;
    localparam int          DIV45_SHIFT   = 29;

    // Inverse CORDIC gain as a Q0.32 constant, split in halves
    localparam logic [15:0] INV_GAIN_HI = 16'h9B74;
    localparam logic [15:0] INV_GAIN_LO = 16'hEDA8;

    // Quadrant codes from the top two bits of the binary angle
    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    // Saturation limits
    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;

    // atan(2^-i) in binary angle units, full turn = 2^32
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // floor(x / 45) for x below 2^24
    function automatic logic [18:0] div45(input logic [23:0] x);
        logic [47:0] prod;
        prod = x * DIV45_RECIP;
        return prod[47:DIV45_SHIFT];
    endfunction

endpackage

### hw/rtl/point_rotate_about_center.sv
// Stages: six angle/offset, one per CORDIC micro-rotation and three gain/saturation,
// one register per stage. Throughput: one transfer per cycle while the output is not
// stalled. A stalled output holds every full stage back to the first bubble; bubbles
// ahead of the stall still close up.
// Reset: aresetn (synchronous, active low) clears the valid bits; the datapath is not reset.
module point_rotate_about_center
    import prac_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: point_x, point_y, center_x, center_y, angle_deg (lowest bits first)
    input  logic [159:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_tdata: rotated_x, rotated_y (lowest bits first)
    output logic [63:0]  m_tdata,
    // m_tuser: overflow
    output logic [0:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready
);

    localparam int AW      = 32 - FRAC_BITS;               // integer degrees width
    localparam int UW      = 34 - FRAC_BITS;               // offset integer degrees
    localparam int ANG_OFS = DEG_FULL * ((2 ** (31 - FRAC_BITS) + DEG_FULL - 1) / DEG_FULL);
    localparam int MLOW    = 29 - FRAC_BITS;
    localparam int XW      = 33 + GUARD_BITS + 4;          // rotation datapath
    localparam int ZW      = 33;                           // residual angle
    localparam int PW      = XW + 17;                      // gain partial products
    localparam int SW      = XW + 18;                      // gain sum
    localparam int GW      = SW - 16 - GUARD_BITS;         // after gain removal
    localparam int NPRE    = 6;
    localparam int NCOR    = CORDIC_STAGES;
    localparam int NST     = NPRE + NCOR + 3;

    // ------------------------------------------------------------------
    // Stage valid bits and advance chain
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] adv;

    // A stage advances when it is empty or the stage after it advances
    always_comb begin
        adv[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        for (int k = 0; k < NST; k++) begin
            if (adv[k]) begin
                vld_next[k] = (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
            end else begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NST-1];

    // ------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------
    coord_t point_x, point_y, center_x, center_y, angle_deg;

    assign point_x   = s_tdata[31:0];
    assign point_y   = s_tdata[63:32];
    assign center_x  = s_tdata[95:64];
    assign center_y  = s_tdata[127:96];
    assign angle_deg = s_tdata[159:128];

    // ------------------------------------------------------------------
    // S1: offsets, integer degrees shifted positive, first divide by 360
    // ------------------------------------------------------------------
    geom_t                s1_geo_reg;
    logic [UW-1:0]        s1_u_reg;
    logic [18:0]          s1_qu_reg;
    logic [FRAC_BITS-1:0] s1_lo_reg;

    geom_t         s1_geo_next;
    logic [AW-1:0] a_hi;
    logic [UW-1:0] s1_u_next;

    always_comb begin
        s1_geo_next.dx = {point_x[31], point_x} - {center_x[31], center_x};
        s1_geo_next.dy = {point_y[31], point_y} - {center_y[31], center_y};
        s1_geo_next.cx = center_x;
        s1_geo_next.cy = center_y;
        a_hi           = angle_deg[31:FRAC_BITS];
        s1_u_next      = {{(UW - AW){a_hi[AW-1]}}, a_hi} + UW'(ANG_OFS);
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_geo_reg <= s1_geo_next;
            s1_u_reg   <= s1_u_next;
            s1_qu_reg  <= div45(24'(s1_u_next >> 3));
            s1_lo_reg  <= angle_deg[FRAC_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // S2: integer degrees mod 360, form the scaled angle word
    // ------------------------------------------------------------------
    geom_t       s2_geo_reg;
    logic [21:0] s2_mh_reg;
    logic [15:0] s2_ml_reg;

    logic [UW-1:0] h_full;
    logic [37:0]   m_word;

    always_comb begin
        h_full = s1_u_reg - UW'(s1_qu_reg * DEG_FULL);
        m_word = {h_full[8:0], s1_lo_reg, MLOW'(ROUND_EIGHTHS)};
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s2_geo_reg <= s1_geo_reg;
            s2_mh_reg  <= m_word[37:16];
            s2_ml_reg  <= m_word[15:0];
        end
    end

    // ------------------------------------------------------------------
    // S3: high quotient digit
    // ------------------------------------------------------------------
    geom_t       s3_geo_reg;
    logic [21:0] s3_mh_reg;
    logic [15:0] s3_ml_reg;
    logic [15:0] s3_q1_reg;
    logic [18:0] q1_full;

    assign q1_full = div45(24'(s2_mh_reg));

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s3_geo_reg <= s2_geo_reg;
            s3_mh_reg  <= s2_mh_reg;
            s3_ml_reg  <= s2_ml_reg;
            s3_q1_reg  <= q1_full[15:0];
        end
    end

    // ------------------------------------------------------------------
    // S4: high remainder joined with the low half
    // ------------------------------------------------------------------
    geom_t       s4_geo_reg;
    logic [15:0] s4_q1_reg;
    logic [21:0] s4_x2_reg;
    logic [21:0] r1_full;

    assign r1_full = s3_mh_reg - 22'(s3_q1_reg * DIV45_DIVISOR);

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s4_geo_reg <= s3_geo_reg;
            s4_q1_reg  <= s3_q1_reg;
            s4_x2_reg  <= {r1_full[5:0], s3_ml_reg};
        end
    end

    // ------------------------------------------------------------------
    // S5: low quotient digit, binary angle complete
    // ------------------------------------------------------------------
    geom_t       s5_geo_reg;
    logic [31:0] s5_turn_reg;
    logic [18:0] q0_full;

    assign q0_full = div45(24'(s4_x2_reg));

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s5_geo_reg  <= s4_geo_reg;
            s5_turn_reg <= {s4_q1_reg, q0_full[15:0]};
        end
    end

    // ------------------------------------------------------------------
    // S6 and CORDIC stages; index 0 holds the quadrant-corrected start
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cor_x_reg   [NCOR+1];
    logic signed [XW-1:0] cor_y_reg   [NCOR+1];
    logic signed [ZW-1:0] cor_z_reg   [NCOR+1];
    center_t              cor_ctr_reg [NCOR+1];

    logic signed [XW-1:0] x0, y0;

    // Scale the offset and apply the exact quarter-turn pre-rotation
    always_comb begin
        x0 = $signed({{(XW - 33 - GUARD_BITS){s5_geo_reg.dx[32]}}, s5_geo_reg.dx,
                      {GUARD_BITS{1'b0}}});
        y0 = $signed({{(XW - 33 - GUARD_BITS){s5_geo_reg.dy[32]}}, s5_geo_reg.dy,
                      {GUARD_BITS{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            unique case (s5_turn_reg[31:30])
                QUAD_0: begin
                    cor_x_reg[0] <= x0;
                    cor_y_reg[0] <= y0;
                end
                QUAD_90: begin
                    cor_x_reg[0] <= -y0;
                    cor_y_reg[0] <= x0;
                end
                QUAD_180: begin
                    cor_x_reg[0] <= -x0;
                    cor_y_reg[0] <= -y0;
                end
                QUAD_270: begin
                    cor_x_reg[0] <= y0;
                    cor_y_reg[0] <= -x0;
                end
                default: begin
                    cor_x_reg[0] <= x0;
                    cor_y_reg[0] <= y0;
                end
            endcase
            cor_z_reg[0]      <= $signed({3'b000, s5_turn_reg[29:0]});
            cor_ctr_reg[0].cx <= s5_geo_reg.cx;
            cor_ctr_reg[0].cy <= s5_geo_reg.cy;
        end
    end

    // One micro-rotation per stage, direction from the residual angle sign
    for (genvar i = 0; i < NCOR; i++) begin : g_cordic
        logic signed [XW-1:0] xs, ys;
        logic signed [ZW-1:0] at;

        assign xs = cor_x_reg[i] >>> i;
        assign ys = cor_y_reg[i] >>> i;
        assign at = $signed({1'b0, ATAN_TURNS[i]});

        always_ff @(posedge aclk) begin
            if (adv[NPRE+i]) begin
                if (!cor_z_reg[i][ZW-1]) begin
                    cor_x_reg[i+1] <= cor_x_reg[i] - ys;
                    cor_y_reg[i+1] <= cor_y_reg[i] + xs;
                    cor_z_reg[i+1] <= cor_z_reg[i] - at;
                end else begin
                    cor_x_reg[i+1] <= cor_x_reg[i] + ys;
                    cor_y_reg[i+1] <= cor_y_reg[i] - xs;
                    cor_z_reg[i+1] <= cor_z_reg[i] + at;
                end
                cor_ctr_reg[i+1] <= cor_ctr_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // G1: partial products with the inverse gain halves
    // ------------------------------------------------------------------
    logic signed [PW-1:0] g1_px_reg, g1_qx_reg, g1_py_reg, g1_qy_reg;
    center_t              g1_ctr_reg;

    always_ff @(posedge aclk) begin
        if (adv[NPRE+NCOR-1+1]) begin
            g1_px_reg  <= cor_x_reg[NCOR] * $signed({1'b0, INV_GAIN_HI});
            g1_qx_reg  <= cor_x_reg[NCOR] * $signed({1'b0, INV_GAIN_LO});
            g1_py_reg  <= cor_y_reg[NCOR] * $signed({1'b0, INV_GAIN_HI});
            g1_qy_reg  <= cor_y_reg[NCOR] * $signed({1'b0, INV_GAIN_LO});
            g1_ctr_reg <= cor_ctr_reg[NCOR];
        end
    end

    // ------------------------------------------------------------------
    // G2: combine halves, round, drop guard bits
    // ------------------------------------------------------------------
    logic signed [GW-1:0] g2_gx_reg, g2_gy_reg;
    center_t              g2_ctr_reg;

    logic signed [SW-1:0] round_q;
    logic signed [SW-1:0] qsx, qsy, sumx, sumy;

    always_comb begin
        round_q = SW'(64'sd1 <<< (31 + GUARD_BITS));
        qsx     = ($signed({g1_qx_reg[PW-1], g1_qx_reg}) + round_q) >>> 16;
        qsy     = ($signed({g1_qy_reg[PW-1], g1_qy_reg}) + round_q) >>> 16;
        sumx    = $signed({g1_px_reg[PW-1], g1_px_reg}) + qsx;
        sumy    = $signed({g1_py_reg[PW-1], g1_py_reg}) + qsy;
    end

    always_ff @(posedge aclk) begin
        if (adv[NST-2]) begin
            g2_gx_reg  <= sumx[SW-1:16+GUARD_BITS];
            g2_gy_reg  <= sumy[SW-1:16+GUARD_BITS];
            g2_ctr_reg <= g1_ctr_reg;
        end
    end

    // ------------------------------------------------------------------
    // G3: add the center back, saturate, output register
    // ------------------------------------------------------------------
    logic signed [GW:0] fx, fy;
    coord_t             out_x_next, out_y_next;
    logic               ovf_next;

    coord_t out_x_reg, out_y_reg;
    logic   out_ovf_reg;

    always_comb begin
        fx       = $signed({{(GW - 31){g2_ctr_reg.cx[31]}}, g2_ctr_reg.cx})
                 + $signed({g2_gx_reg[GW-1], g2_gx_reg});
        fy       = $signed({{(GW - 31){g2_ctr_reg.cy[31]}}, g2_ctr_reg.cy})
                 + $signed({g2_gy_reg[GW-1], g2_gy_reg});
        ovf_next = 1'b0;
        // Clamp x
        if (fx > $signed((GW + 1)'(COORD_MAX))) begin
            out_x_next = COORD_MAX;
            ovf_next   = 1'b1;
        end else if (fx < $signed({{(GW - 31){1'b1}}, COORD_MIN})) begin
            out_x_next = COORD_MIN;
            ovf_next   = 1'b1;
        end else begin
            out_x_next = fx[31:0];
        end
        // Clamp y
        if (fy > $signed((GW + 1)'(COORD_MAX))) begin
            out_y_next = COORD_MAX;
            ovf_next   = 1'b1;
        end else if (fy < $signed({{(GW - 31){1'b1}}, COORD_MIN})) begin
            out_y_next = COORD_MIN;
            ovf_next   = 1'b1;
        end else begin
            out_y_next = fy[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[NST-1]) begin
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
            out_ovf_reg <= ovf_next;
        end
    end

    assign m_tdata    = {out_y_reg, out_x_reg};
    assign m_tuser[0] = out_ovf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Input is held back only when the whole pipeline is full behind a stalled output
    a_stall_only_when_full: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready)
    ) else $error("input stalled while pipeline has room");

    // Overflow flag implies a coordinate sits at a saturation limit
    a_ovf_means_clamped: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[31:0] == COORD_MAX || m_tdata[31:0] == COORD_MIN ||
             m_tdata[63:32] == COORD_MAX || m_tdata[63:32] == COORD_MIN)
    ) else $error("overflow set without a saturated coordinate");

    // No result right after reset release
    a_empty_after_reset: assert property (
        @(posedge aclk)
        $rose(aresetn) |-> !m_tvalid
    ) else $error("result valid right after reset");

endmodule

### dv/rotation_checker.sv
module rotation_checker
    import prac_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: point_x, point_y, center_x, center_y, angle_deg (lowest bits first)
    input  logic [159:0] s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // m_tdata: rotated_x, rotated_y (lowest bits first)
    input  logic [63:0]  m_tdata,
    // m_tuser: overflow
    input  logic [0:0]   m_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    output int           mismatches,
    output int           awaiting,
    output int           points_checked,
    output int           saturated_seen
);

    // Extra fraction bits carried by the offset through the micro-rotations
    localparam int GUARD = 8;

    // One full turn in degrees
    localparam longint FULL_TURN_DEG = 360;

    // Inverse CORDIC gain, Q0.32, as two 16-bit halves
    localparam longint GAIN_UPPER = 64'sh9B74;
    localparam longint GAIN_LOWER = 64'shEDA8;
    localparam longint GAIN_ROUND = 64'sd1 <<< (31 + GUARD);

    // Micro-rotation angles atan(2^-i), full turn = 2^32
    localparam logic [31:0] ARCTAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        coord_t rx;
        coord_t ry;
        logic   ovf;
    } rotated_point_t;

    rotated_point_t expected_points[$];

    // Map degrees onto a 32-bit binary angle, rounding to nearest, ties up
    function automatic logic [31:0] binary_angle(input logic signed [31:0] ang);
        longint          full, r;
        longint unsigned full_u, scaled, whole, rem, frac, sum;
        full = FULL_TURN_DEG <<< FRAC_BITS;
        r = longint'(ang) % full;
        if (r < 0)
            r += full;
        full_u = full;
        scaled = r;
        scaled = scaled << 16;
        whole  = scaled / full_u;
        rem    = scaled % full_u;
        frac   = ((rem << 16) + full_u / 2) / full_u;
        sum    = (whole << 16) + frac;
        return sum[31:0];
    endfunction

    // Multiply by the inverse gain, drop guard bits, round half up
    function automatic longint strip_gain(input longint v);
        longint upper, lower;
        upper = v * GAIN_UPPER;
        lower = v * GAIN_LOWER + GAIN_ROUND;
        return (upper + (lower >>> 16)) >>> (16 + GUARD);
    endfunction

    // Clamp to the coordinate range; top bit flags a clamp
    function automatic logic [32:0] clamp_coord(input longint v);
        if (v > longint'(COORD_MAX))
            return {1'b1, COORD_MAX};
        if (v < longint'(COORD_MIN))
            return {1'b1, COORD_MIN};
        return {1'b0, v[31:0]};
    endfunction

    function automatic rotated_point_t predict_rotation(input logic [159:0] item);
        coord_t         px, py, cx, cy;
        logic [31:0]    turn;
        longint         x, y, z, t, xs, ys, step;
        logic [32:0]    fx, fy;
        rotated_point_t res;
        px = item[31:0];
        py = item[63:32];
        cx = item[95:64];
        cy = item[127:96];
        x = (longint'(px) - longint'(cx)) <<< GUARD;
        y = (longint'(py) - longint'(cy)) <<< GUARD;
        turn = binary_angle(item[159:128]);
        z = {34'd0, turn[29:0]};

        // Exact quarter-turn pre-rotation
        case (turn[31:30])
            QUAD_90: begin
                t = x; x = -y; y = t;
            end
            QUAD_180: begin
                x = -x; y = -y;
            end
            QUAD_270: begin
                t = x; x = y; y = -t;
            end
            default: ;
        endcase

        // Micro-rotations, driving the residual angle toward zero
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            step = {32'd0, ARCTAN_STEP[i]};
            if (z >= 0) begin
                x -= ys; y += xs; z -= step;
            end else begin
                x += ys; y -= xs; z += step;
            end
        end

        fx = clamp_coord(longint'(cx) + strip_gain(x));
        fy = clamp_coord(longint'(cy) + strip_gain(y));
        res.rx  = fx[31:0];
        res.ry  = fy[31:0];
        res.ovf = fx[32] | fy[32];
        return res;
    endfunction

    initial begin
        mismatches     = 0;
        awaiting       = 0;
        points_checked = 0;
        saturated_seen = 0;
    end

    // Compare each output transfer with the oldest prediction, then log new inputs
    always @(posedge aclk) begin : watch_channels
        rotated_point_t want, got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.rx  = m_tdata[31:0];
                got.ry  = m_tdata[63:32];
                got.ovf = m_tuser[0];
                if (got.ovf)
                    saturated_seen++;
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result x=%08h y=%08h ovf=%0b",
                                 got.rx, got.ry, got.ovf);
                end else begin
                    want = expected_points.pop_front();
                    if (got.rx !== want.rx || got.ry !== want.ry || got.ovf !== want.ovf)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d%s%s%s: expected x=%08h y=%08h ovf=%0b, got x=%08h y=%08h ovf=%0b",
                                     points_checked,
                                     (got.rx !== want.rx) ? " [x]" : "",
                                     (got.ry !== want.ry) ? " [y]" : "",
                                     (got.ovf !== want.ovf) ? " [ovf]" : "",
                                     want.rx, want.ry, want.ovf, got.rx, got.ry, got.ovf);
                    end
                    points_checked++;
                end
            end
            if (s_tvalid && s_tready)
                expected_points.push_back(predict_rotation(s_tdata));
            awaiting = expected_points.size();
        end
    end

endmodule

### dv/tb_point_rotate_about_center.sv
module tb_point_rotate_about_center;

    localparam int STAGES        = 16;
    localparam int ANGLE_FRAC    = 16;
    localparam int RANDOM_POINTS = 930;
    localparam int CALM_POINTS   = 120;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 5000;

    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE   = 32'h0001_0000;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic [159:0] s_tdata  = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;

    int mismatches, awaiting, points_checked, saturated_seen;
    int points_sent = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    always #4 aclk = ~aclk;

    point_rotate_about_center #(
        .CORDIC_STAGES(STAGES),
        .FRAC_BITS    (ANGLE_FRAC)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    rotation_checker #(
        .CORDIC_STAGES(STAGES),
        .FRAC_BITS    (ANGLE_FRAC)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .mismatches    (mismatches),
        .awaiting      (awaiting),
        .points_checked(points_checked),
        .saturated_seen(saturated_seen)
    );

    // Whole degrees to the angle format
    function automatic logic [31:0] deg_q(input int d);
        return d * (1 << ANGLE_FRAC);
    endfunction

    // Coordinate: mostly small or mid-range, some full-width, some extremes
    function automatic logic [31:0] pick_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1:       return r;
            2, 3, 4, 5: return {{11{r[20]}}, r[20:0]};
            6, 7, 8:    return {{3{r[28]}}, r[28:0]};
            default: begin
                case ($urandom_range(0, 5))
                    0:       return C_MAX;
                    1:       return C_MIN;
                    2:       return 32'h0;
                    3:       return 32'hFFFF_FFFF;
                    4:       return 32'h1;
                    default: return ONE;
                endcase
            end
        endcase
    endfunction

    // Angle: full-width, a few turns either way, near quarter turns, extremes
    function automatic logic [31:0] pick_angle();
        logic [31:0] r;
        int          k;
        r = $urandom;
        k = $urandom_range(0, 8);
        case ($urandom_range(0, 8))
            0, 1, 2, 3: return r;
            4, 5, 6:    return {{6{r[25]}}, r[25:0]};
            7:          return deg_q((k - 4) * 90) + $urandom_range(0, 2) - 1;
            default:    return (r[0]) ? C_MAX : C_MIN;
        endcase
    endfunction

    // Offer one point; optionally idle first, then hold until the transfer
    task automatic offer_point(input logic [31:0] px, py, cx, cy, ang, input bit steady);
        if (!steady && !calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom};
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tdata  <= {ang, cy, cx, py, px};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        points_sent++;
        @(negedge aclk);
    endtask

    // Receiver: random stall bursts, one long hold, always ready near the end
    initial begin : drain_side
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
        end
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, awaiting);
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] cx, cy;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Quarter turns, full turn and negative turn about the origin
        offer_point(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        offer_point(ONE, 32'h0, 32'h0, 32'h0, deg_q(90), 1'b0);
        offer_point(ONE, 32'h0, 32'h0, 32'h0, deg_q(180), 1'b0);
        offer_point(ONE, 32'h0, 32'h0, 32'h0, deg_q(270), 1'b0);
        offer_point(ONE, 32'h0, 32'h0, 32'h0, deg_q(360), 1'b0);
        offer_point(ONE, 32'h0, 32'h0, 32'h0, deg_q(-90), 1'b0);

        // Off-origin centers, fractional angles, quadrant boundaries
        offer_point(3 * ONE, 4 * ONE, ONE, ONE, deg_q(45), 1'b0);
        offer_point(3 * ONE, 4 * ONE, ONE, ONE, deg_q(30) + 32'h8000, 1'b0);
        offer_point(5 * ONE, -2 * ONE, ONE, 3 * ONE, 32'h1, 1'b0);
        offer_point(100 * ONE, -50 * ONE, 2 * ONE, 3 * ONE, C_MAX, 1'b0);
        offer_point(100 * ONE, -50 * ONE, 2 * ONE, 3 * ONE, C_MIN, 1'b0);
        offer_point(7 * ONE, ONE, -ONE, 2 * ONE, deg_q(90) - 1, 1'b0);
        offer_point(7 * ONE, ONE, -ONE, 2 * ONE, deg_q(90) + 1, 1'b0);
        offer_point(-9 * ONE, 6 * ONE, 0, 0, deg_q(810), 1'b0);
        offer_point(-9 * ONE, 6 * ONE, 0, 0, deg_q(-3600), 1'b0);

        // Point coincides with center
        offer_point(12 * ONE, -8 * ONE, 12 * ONE, -8 * ONE, deg_q(123) + 32'h4000, 1'b0);
        offer_point(C_MAX, C_MAX, C_MAX, C_MAX, deg_q(90), 1'b0);

        // Widest offsets and saturating results
        offer_point(C_MAX, C_MAX, C_MIN, C_MIN, 32'h0, 1'b0);
        offer_point(C_MIN, C_MIN, C_MAX, C_MAX, deg_q(180), 1'b0);
        offer_point(C_MIN, C_MIN, 32'h0, 32'h0, deg_q(180), 1'b0);
        offer_point(C_MAX, C_MAX, 32'h0, 32'h0, deg_q(45), 1'b0);
        offer_point(C_MIN, C_MAX, C_MAX, C_MIN, deg_q(270), 1'b0);
        offer_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 1'b0);

        // Random points; a back-to-back run covers the long output hold
        for (int n = 0; n < RANDOM_POINTS; n++) begin
            calm = (n >= RANDOM_POINTS - CALM_POINTS);
            if (n == HOLD_AT)
                hold_req = 1'b1;
            cx = pick_coord();
            cy = pick_coord();
            if ($urandom_range(0, 3) == 0) begin
                cx = '0;
                cy = '0;
            end
            offer_point(pick_coord(), pick_coord(), cx, cy, pick_angle(),
                        n >= HOLD_AT && n < HOLD_AT + 80);
        end
        s_tvalid <= 1'b0;

        // Drain the pipeline, then allow a few more cycles for strays
        while (awaiting != 0)
            @(negedge aclk);
        repeat (STAGES + 12) @(negedge aclk);

        $display("Sent %0d points: quarter turns, wrapped and extreme angles, extreme offsets,",
                 points_sent);
        $display("random centers and angles; checked %0d results, %0d saturated.",
                 points_checked, saturated_seen);
        if (mismatches == 0 && awaiting == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
